@@ rtl/core/mono_page_framebuffer_assert.svh @@
// assertion macros for the mono page framebuffer checks
`ifndef MONO_PAGE_FRAMEBUFFER_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mono_page_framebuffer: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MPFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mono_page_framebuffer: next-cycle check failed");

`endif

@@ rtl/core/mpfb_pkg.sv @@
// shared types, constants and helpers of the mono page framebuffer
`timescale 1ns / 1ps
`default_nettype none

package mpfb_pkg;

    // frame store geometry
    localparam int PAGES     = 8;
    localparam int COLUMNS   = 128;
    localparam int MEM_DEPTH = PAGES * COLUMNS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // panel bus command bytes
    localparam logic [7:0] CMD_PAGE_BASE   = 8'hb0;
    localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;
    localparam logic [3:0] COL_NIBBLE_MASK = 4'hf;

    // register reset values
    localparam logic [7:0] WIDTH_RESET  = 8'd128;
    localparam logic [7:0] HEIGHT_RESET = 8'd64;

    // configuration register indexes
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PORTRAIT     = 2'd2;

    // input command codes
    localparam logic [1:0] CMD_PLOT    = 2'd0;
    localparam logic [1:0] CMD_STORE   = 2'd1;
    localparam logic [1:0] CMD_REFRESH = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
        logic       black;
        logic [2:0] page;
        logic [6:0] column;
        logic       row_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_PLOT,
        OP_STORE,
        OP_REFRESH
    } op_t;

    // one classified job as it travels from front to back
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              black;
        logic              send_addr;
        logic [3:0]        page;
        logic [6:0]        column;
        logic              in_store;
    } job_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [4:0] pg,
                                                   input logic [6:0] col);
        return ADDR_W'(ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mpfb_front.sv @@
// front end: configuration registers, item intake and classification
`timescale 1ns / 1ps
`default_nettype none

module mpfb_front
    import mpfb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  in_data,
    input  wire logic      clearing,
    input  wire logic      q_full,
    output logic           q_push,
    output job_t           q_job
);

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic       portrait_reg;

    logic [6:0] p_col;
    logic [6:0] p_row;
    logic       p_in_view;
    logic       p_in_store;
    logic [7:0] s_w;
    logic [7:0] s_h;
    logic [6:0] s_x;
    logic [6:0] s_y;
    logic [6:0] s_col;
    logic [7:0] s_row;
    logic       s_in_store;
    logic       r_in_store;
    logic       keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            portrait_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PANEL_WIDTH:  width_reg    <= cfg_data;
                REG_PANEL_HEIGHT: height_reg   <= cfg_data;
                REG_PORTRAIT:     portrait_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // plot: bounds check in view, then swap axes in portrait
    assign p_col      = portrait_reg ? in_data.pixel_y : in_data.pixel_x;
    assign p_row      = portrait_reg ? in_data.pixel_x : in_data.pixel_y;
    assign p_in_view  = ({1'b0, in_data.pixel_x} < width_reg)
                     && ({1'b0, in_data.pixel_y} < height_reg);
    assign p_in_store = (int'(p_row[6:3]) < PAGES) && (int'(p_col) < COLUMNS);

    // store only: clamp, zero size acts as one, portrait mirrors x
    assign s_w        = (width_reg == 8'd0) ? 8'd1 : width_reg;
    assign s_h        = (height_reg == 8'd0) ? 8'd1 : height_reg;
    assign s_x        = ({1'b0, in_data.pixel_x} >= s_w) ? 7'(s_w - 8'd1) : in_data.pixel_x;
    assign s_y        = ({1'b0, in_data.pixel_y} >= s_h) ? 7'(s_h - 8'd1) : in_data.pixel_y;
    assign s_col      = portrait_reg ? s_y : s_x;
    assign s_row      = portrait_reg ? (s_w - 8'd1 - {1'b0, s_x}) : {1'b0, s_y};
    assign s_in_store = (int'(s_row[7:3]) < PAGES) && (int'(s_col) < COLUMNS);

    // refresh: out of store still sends, with zero data
    assign r_in_store = (int'(in_data.page) < PAGES) && (int'(in_data.column) < COLUMNS);

    always_comb
    begin
        keep  = 1'b0;
        q_job = '0;
        case (in_data.cmd)
            CMD_PLOT:
            begin
                keep              = p_in_view && p_in_store;
                q_job.op          = OP_PLOT;
                q_job.addr        = mem_addr({1'b0, p_row[6:3]}, p_col);
                q_job.bit_sel     = p_row[2:0];
                q_job.black       = in_data.black;
                q_job.send_addr   = 1'b1;
                q_job.page        = p_row[6:3];
                q_job.column      = p_col;
                q_job.in_store    = 1'b1;
            end
            CMD_STORE:
            begin
                keep              = s_in_store;
                q_job.op          = OP_STORE;
                q_job.addr        = mem_addr(s_row[7:3], s_col);
                q_job.bit_sel     = s_row[2:0];
                q_job.black       = in_data.black;
                q_job.in_store    = 1'b1;
            end
            CMD_REFRESH:
            begin
                keep              = 1'b1;
                q_job.op          = OP_REFRESH;
                q_job.addr        = mem_addr({2'b00, in_data.page}, in_data.column);
                q_job.send_addr   = in_data.row_start;
                q_job.page        = {1'b0, in_data.page};
                q_job.column      = in_data.column;
                q_job.in_store    = r_in_store;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full   = q_full || clearing;
    assign q_push = push && !full && keep;

endmodule

`default_nettype wire

@@ rtl/core/mpfb_queue.sv @@
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module mpfb_queue
    import mpfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      q_full,
    input  wire logic rd_en,
    output logic      q_empty,
    output job_t      rd_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mpfb_back.sv @@
// back end: frame store, read-modify-write and bus byte serializer
`timescale 1ns / 1ps
`default_nettype none

module mpfb_back
    import mpfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t q_job,
    output logic      q_pop,
    output logic      clearing,
    input  wire logic pop,
    output logic      empty,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SLOT_PAGE,
        SLOT_COL_HI,
        SLOT_COL_LO,
        SLOT_DATA
    } slot_t;

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;

    state_t            state_reg,     state_next;
    job_t              cur_reg,       cur_next;
    slot_t             slot_reg,      slot_next;
    logic [7:0]        data_reg,      data_next;
    logic [ADDR_W-1:0] clr_cnt_reg,   clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg,  out_item_next;

    logic              mem_rd_en;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic [7:0]        bit_mask;
    logic [7:0]        modified;
    logic              out_ready;
    out_item_t         slot_item;

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[q_job.addr];
        end
    end

    assign bit_mask  = 8'd1 << cur_reg.bit_sel;
    assign modified  = cur_reg.black ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
    assign out_ready = !out_valid_reg || pop;

    always_comb
    begin
        slot_item = '0;
        case (slot_reg)
            SLOT_PAGE:
            begin
                slot_item.out_byte   = CMD_PAGE_BASE + {4'd0, cur_reg.page};
                slot_item.is_command = 1'b1;
            end
            SLOT_COL_HI:
            begin
                slot_item.out_byte   = CMD_COL_HI_BASE + {5'd0, cur_reg.column[6:4]};
                slot_item.is_command = 1'b1;
            end
            SLOT_COL_LO:
            begin
                slot_item.out_byte   = {4'd0, cur_reg.column[3:0] & COL_NIBBLE_MASK};
                slot_item.is_command = 1'b1;
            end
            default:
            begin
                slot_item.out_byte   = data_reg;
                slot_item.last       = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        data_next      = data_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_item_next  = out_item_reg;
        q_pop          = 1'b0;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cur_reg.addr;
        mem_wr_data    = modified;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                mem_wr_data = '0;
                if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    mem_rd_en  = 1'b1;
                    cur_next   = q_job;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                case (cur_reg.op)
                    OP_STORE:
                    begin
                        mem_wr_en  = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_PLOT:
                    begin
                        mem_wr_en  = 1'b1;
                        data_next  = modified;
                        slot_next  = SLOT_PAGE;
                        state_next = S_EMIT;
                    end
                    OP_REFRESH:
                    begin
                        data_next  = cur_reg.in_store ? rd_data_reg : 8'd0;
                        slot_next  = cur_reg.send_addr ? SLOT_PAGE : SLOT_DATA;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = slot_item;
                    case (slot_reg)
                        SLOT_PAGE:   slot_next  = SLOT_COL_HI;
                        SLOT_COL_HI: slot_next  = SLOT_COL_LO;
                        SLOT_COL_LO: slot_next  = SLOT_DATA;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            slot_reg      <= SLOT_PAGE;
            data_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            slot_reg      <= slot_next;
            data_reg      <= data_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign clearing = (state_reg == S_CLEAR);
    assign empty    = !out_valid_reg;
    assign out_data = out_item_reg;

endmodule

`default_nettype wire

@@ rtl/core/mono_page_framebuffer.sv @@
// top level of the monochrome page-addressed frame store
//
//  channel   direction  handshake              payload
//  input     in         push / full            in_data    (in_item_t)
//  result    out        empty / pop            out_data   (out_item_t)
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a job leaves the queue and starts its store read in the same cycle, then its
// read-modify-write follows (a plain read for a refresh), then its bus bytes go
// out, one per cycle while the output register can take them: four bytes for a
// plot or an addressed refresh, one for a plain refresh, none for a store-only write
// after reset a clearing pass zeroes the 1024-byte store,
// with full held high; config writes are taken throughout
// a stalled result holds in the output register while the back end waits

`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer
    import mpfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire in_item_t   in_data,
    output logic            empty,
    input  wire logic       pop,
    output out_item_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // front to queue
    logic q_push;
    job_t q_wr_job;
    logic q_full;

    // queue to back
    logic q_pop;
    logic q_empty;
    job_t q_rd_job;

    // back status: store clearing after reset
    logic clearing;

    // front: register file, bounds, clamping, orientation and address
    mpfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_wr_job)
    );

    // decoupling queue, lets intake run ahead of the serializer
    mpfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (q_wr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_job  (q_rd_job)
    );

    // back: frame store, pixel update and panel byte stream
    mpfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (q_rd_job),
        .q_pop    (q_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/mpfb_checker.sv @@
// port-level checks on the mono page framebuffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "mono_page_framebuffer_assert.svh"

module mpfb_checker
    import mpfb_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire out_item_t out_data
);

    // a waiting result holds until taken
    `MPFB_ASSERT_NEXT(a_result_holds, (!empty && !pop), (!empty && $stable(out_data)))

    // data bytes close a transaction, command bytes never do
    `MPFB_ASSERT_NOW(a_last_on_data, !empty, (out_data.is_command != out_data.last))

    // a page command is followed at once by its column-high command
    `MPFB_ASSERT_NEXT(a_page_then_col,
        (pop && !empty && out_data.is_command
            && out_data.out_byte[7:4] == CMD_PAGE_BASE[7:4]),
        (!empty && out_data.is_command
            && out_data.out_byte[7:4] == CMD_COL_HI_BASE[7:4]))

endmodule

bind mono_page_framebuffer mpfb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
);

`default_nettype wire

@@ dv/mono_page_framebuffer_tb.sv @@
// self-checking testbench for the monochrome page-addressed frame store
`timescale 1ns / 1ps

module mono_page_framebuffer_tb;

    import mpfb_pkg::*;

    // cmd code with no defined behavior, the block drops it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 32;      // quiet time after the last expected byte
    localparam int CYCLE_LIMIT   = 200000;  // clearing pass plus slowest run, many times over
    localparam int REPORT_LIMIT  = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_data = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mono_page_framebuffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // -------------------------------------------------------------------
    // mirror of the block: frame store and panel registers
    // -------------------------------------------------------------------
    logic [7:0] shadow_frame [PAGES*COLUMNS];
    int         panel_w = WIDTH_RESET;
    int         panel_h = HEIGHT_RESET;
    bit         portrait_mode = 1'b0;

    in_item_t   pending_items [$];   // items waiting for the driver
    out_item_t  bus_expected [$];    // bus bytes the block still owes us

    int  mismatches = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold_req = 1'b0;
    bit  rx_hold_done = 1'b0;

    function automatic void expect_bus_byte(input logic [7:0] b, input logic is_cmd,
                                            input logic is_last);
        out_item_t e;
        e.out_byte   = b;
        e.is_command = is_cmd;
        e.last       = is_last;
        bus_expected.push_back(e);
    endfunction

    // page, column-high and column-low commands ahead of a data byte
    function automatic void expect_addressing(input int pg, input int col);
        expect_bus_byte(CMD_PAGE_BASE + 8'(pg & 15), 1'b1, 1'b0);
        expect_bus_byte(CMD_COL_HI_BASE + 8'((col >> 4) & COL_NIBBLE_MASK), 1'b1, 1'b0);
        expect_bus_byte(8'(col & COL_NIBBLE_MASK), 1'b1, 1'b0);
    endfunction

    // set or clear one pixel, returns 0 when it falls outside the store
    function automatic bit write_pixel(input int col, input int row, input logic black);
        int pg;
        int addr;
        pg = row >> 3;
        if (pg >= PAGES || col >= COLUMNS)
            return 1'b0;
        addr = pg * COLUMNS + col;
        if (black)
            shadow_frame[addr] = shadow_frame[addr] | (8'd1 << (row & 7));
        else
            shadow_frame[addr] = shadow_frame[addr] & ~(8'd1 << (row & 7));
        return 1'b1;
    endfunction

    // bus bytes that one accepted item produces, updating the mirror store
    function automatic void predict_bus_bytes(input in_item_t it);
        int x;
        int y;
        int c;
        int r;
        int w;
        int h;
        int pg;
        int col;
        logic [7:0] data;
        x = it.pixel_x;
        y = it.pixel_y;
        case (it.cmd)
            CMD_PLOT:
            begin
                // off-panel plots are dropped silently
                if (x >= panel_w || y >= panel_h)
                    return;
                c = portrait_mode ? y : x;
                r = portrait_mode ? x : y;
                if (!write_pixel(c, r, it.black))
                    return;
                expect_addressing(r >> 3, c);
                expect_bus_byte(shadow_frame[(r >> 3) * COLUMNS + c], 1'b0, 1'b1);
            end
            CMD_STORE:
            begin
                // clamp to the panel, a zero register acts as one
                w = (panel_w == 0) ? 1 : panel_w;
                h = (panel_h == 0) ? 1 : panel_h;
                if (x >= w)
                    x = w - 1;
                if (y >= h)
                    y = h - 1;
                c = portrait_mode ? y : x;
                r = portrait_mode ? (w - 1 - x) : y;
                void'(write_pixel(c, r, it.black));
            end
            CMD_REFRESH:
            begin
                pg   = it.page;
                col  = it.column;
                data = '0;
                if (pg < PAGES && col < COLUMNS)
                    data = shadow_frame[pg * COLUMNS + col];
                if (it.row_start)
                    expect_addressing(pg, col);
                expect_bus_byte(data, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // -------------------------------------------------------------------
    // driver: offers queued items, predicts on each accepted transaction
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_bus_bytes(in_data);
            // a refused item stays on the port until taken
            if (!push || !full)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    push    <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // monitor: pops bus bytes and compares with the oldest expectation
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (bus_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected bus byte %02h cmd %0b last %0b",
                                 out_data.out_byte, out_data.is_command, out_data.last);
                end
                else
                begin
                    e = bus_expected.pop_front();
                    if (out_data.out_byte !== e.out_byte || out_data.is_command !== e.is_command
                        || out_data.last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("bus byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     e.out_byte, e.is_command, e.last,
                                     out_data.out_byte, out_data.is_command, out_data.last);
                    end
                end
            end
            // long hold-off lets the input side back up
            if (rx_hold_req && !rx_hold_done)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // hold-off length counted here, independent of the stimulus
    initial
    begin
        wait (rx_hold_req);
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_done <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------

    // all three panel registers back to back; caller keeps the block idle, not enforced
    task automatic write_panel_regs(input int w, input int h, input bit port);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        int i;
        idx[0] = REG_PANEL_WIDTH;
        idx[1] = REG_PANEL_HEIGHT;
        idx[2] = REG_PORTRAIT;
        val[0] = 8'(w);
        val[1] = 8'(h);
        val[2] = {7'd0, port};
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                REG_PANEL_WIDTH:  panel_w = val[i];
                REG_PANEL_HEIGHT: panel_h = val[i];
                REG_PORTRAIT:     portrait_mode = val[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // one item with every field chosen by the caller
    task automatic queue_item(input logic [1:0] cmd, input int x, input int y,
                              input logic black, input int pg, input int col,
                              input logic rs);
        in_item_t it;
        it.cmd       = cmd;
        it.pixel_x   = 7'(x);
        it.pixel_y   = 7'(y);
        it.black     = black;
        it.page      = 3'(pg);
        it.column    = 7'(col);
        it.row_start = rs;
        pending_items.push_back(it);
    endtask

    function automatic int pick_coord(input int lim);
        return (lim > 0) ? $urandom_range(lim > 128 ? 127 : lim - 1) : 0;
    endfunction

    // mostly refresh runs and on-panel pixels near the origin, plus noise
    task automatic queue_random(input int n);
        int made;
        int len;
        int pg;
        int col;
        int i;
        int shape;
        int sel;
        int x;
        int y;
        logic [1:0] cmd;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(3) == 0)
            begin
                // a page run: addressing on the first byte only
                len = $urandom_range(2, 6);
                pg  = $urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(1);
                col = $urandom_range(1) ? $urandom_range(15) : $urandom_range(127 - len);
                for (i = 0; i < len; i++)
                    queue_item(CMD_REFRESH, $urandom_range(127), $urandom_range(127),
                               $urandom_range(1), pg, col + i, i == 0);
                made += len;
            end
            else
            begin
                shape = $urandom_range(2);
                sel   = $urandom_range(99);
                if (shape == 0)
                begin
                    x = $urandom_range(127);
                    y = $urandom_range(127);
                end
                else if (shape == 1)
                begin
                    x = pick_coord(panel_w);
                    y = pick_coord(panel_h);
                end
                else
                begin
                    x = $urandom_range(15);
                    y = $urandom_range(15);
                end
                if (sel < 40)
                    cmd = CMD_PLOT;
                else if (sel < 65)
                    cmd = CMD_STORE;
                else if (sel < 95)
                    cmd = CMD_REFRESH;
                else
                    cmd = CMD_UNUSED;
                queue_item(cmd, x, y, $urandom_range(1),
                           shape == 2 ? $urandom_range(1) : $urandom_range(7),
                           shape == 2 ? $urandom_range(15) : $urandom_range(127),
                           $urandom_range(1));
                made++;
            end
        end
    endtask

    // every item taken and every expected byte seen, then let stores settle
    // sampled away from the rising edge so the driver's updates have landed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || push || bus_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // -------------------------------------------------------------------
    // test sequence
    // -------------------------------------------------------------------
    initial
    begin
        int i;
        for (i = 0; i < PAGES*COLUMNS; i++)
            shadow_frame[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry, 128 x 64 landscape; registers are taken during the clearing pass
        write_panel_regs(WIDTH_RESET, HEIGHT_RESET, 1'b0);
        set_idling(21, 69);
        queue_item(CMD_PLOT, 0, 0, 1'b1, 7, 127, 1'b1);        // origin corner
        queue_item(CMD_PLOT, 127, 63, 1'b1, 0, 0, 1'b0);       // far corner, page 7
        queue_item(CMD_PLOT, 0, 64, 1'b1, 0, 0, 1'b1);         // just below the panel
        queue_item(CMD_PLOT, 127, 127, 1'b1, 7, 127, 1'b1);    // row off-panel, column on the last one
        queue_item(CMD_PLOT, 127, 63, 1'b0, 7, 127, 1'b1);     // clear it again
        queue_item(CMD_STORE, 127, 127, 1'b1, 0, 0, 1'b0);     // clamped to 127, 63
        queue_item(CMD_REFRESH, 0, 0, 1'b0, 7, 127, 1'b1);     // reads the clamped pixel
        queue_item(CMD_REFRESH, 127, 127, 1'b1, 0, 0, 1'b0);   // origin byte, no addressing
        queue_item(CMD_UNUSED, 127, 127, 1'b1, 7, 127, 1'b1);  // dropped
        queue_item(CMD_STORE, 5, 9, 1'b1, 0, 0, 1'b0);
        queue_item(CMD_STORE, 5, 10, 1'b1, 0, 0, 1'b0);
        queue_item(CMD_REFRESH, 0, 0, 1'b0, 1, 5, 1'b1);
        queue_random(50);
        wait_drained();

        // portrait, full height; the long hold-off lands here
        write_panel_regs(128, 128, 1'b1);
        rx_hold_req <= 1'b1;
        queue_item(CMD_PLOT, 127, 127, 1'b1, 0, 0, 1'b1);      // row past the store
        queue_item(CMD_PLOT, 5, 100, 1'b1, 0, 0, 1'b0);        // swapped to column 100, row 5
        queue_item(CMD_STORE, 0, 3, 1'b1, 0, 0, 1'b0);         // mirrored to row 127, outside
        queue_item(CMD_STORE, 127, 3, 1'b1, 0, 0, 1'b0);       // mirrored to row 0
        queue_item(CMD_REFRESH, 0, 0, 1'b0, 0, 3, 1'b1);
        queue_item(CMD_REFRESH, 0, 0, 1'b0, 0, 100, 1'b0);
        queue_random(50);
        wait_drained();

        // single pixel panel
        write_panel_regs(1, 1, 1'b0);
        set_idling(69, 21);
        queue_item(CMD_PLOT, 0, 0, 1'b1, 0, 0, 1'b0);
        queue_item(CMD_PLOT, 1, 0, 1'b1, 0, 0, 1'b0);          // one past the width
        queue_item(CMD_STORE, 127, 127, 1'b0, 0, 0, 1'b0);     // clamped onto the origin
        queue_item(CMD_REFRESH, 0, 0, 1'b0, 0, 0, 1'b1);
        queue_random(30);
        wait_drained();

        // zero-size registers: plots all rejected, store-only treats them as one
        write_panel_regs(0, 0, 1'b1);
        queue_random(20);
        wait_drained();

        // random geometry, with a pause for a full drain halfway through
        write_panel_regs($urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(1));
        queue_random(30);
        wait_drained();
        queue_random(30);
        wait_drained();

        // back to back, no idling on either side
        write_panel_regs(128, 128, 1'b0);
        set_idling(0, 0);
        queue_random(60);
        wait_drained();

        write_panel_regs($urandom_range(1, 128), $urandom_range(1, 128), 1'b1);
        queue_random(50);
        wait_drained();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
